@@ rtl/owgm_pkg.sv @@
// Shared types and constants for the octant window maximum grid.
// Used by the interfaces, the register block, the controller and the datapath.
// No dependencies.
`default_nettype none

package owgm_pkg;

	localparam int COORD_BITS_DEF = 6;
	localparam int CELL_W = 6;
	localparam int LEVEL_W = 8;
	localparam int DROP_W = 4;
	localparam int SHIFT_W = 5;
	localparam int CORNER_W = 3;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_SHIFT_X = 2'd0;
	localparam reg_idx_t REG_SHIFT_Y = 2'd1;
	localparam reg_idx_t REG_SHIFT_Z = 2'd2;
	localparam reg_idx_t REG_HALF_RES = 2'd3;

	localparam logic FUNC_ACC = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC,
		ST_FLUSH,
		ST_READ,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic [SHIFT_W-1:0] shift_x;
		logic [SHIFT_W-1:0] shift_y;
		logic [SHIFT_W-1:0] shift_z;
		logic               half_res;
	} cfg_t;

	typedef struct packed {
		logic clr_step;
		logic capture;
		logic issue;
		logic read_issue;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic corner_last;
	} sts_t;

endpackage

`default_nettype wire

@@ rtl/owgm_in_if.sv @@
// Input channel of the octant window maximum grid: one word per item.
// Depends on owgm_pkg for field widths.
`default_nettype none

interface owgm_in_if;
	logic                                valid;
	logic                                ready;
	logic                                func;
	logic signed [owgm_pkg::CELL_W-1:0]  cell_x;
	logic signed [owgm_pkg::CELL_W-1:0]  cell_y;
	logic signed [owgm_pkg::CELL_W-1:0]  cell_z;
	logic        [owgm_pkg::LEVEL_W-1:0] cell_level;

	modport source(output valid, func, cell_x, cell_y, cell_z, cell_level, input ready);
	modport sink(input valid, func, cell_x, cell_y, cell_z, cell_level, output ready);
endinterface

`default_nettype wire

@@ rtl/owgm_out_if.sv @@
// Result channel of the octant window maximum grid: one word per item.
// Depends on owgm_pkg for field widths.
`default_nettype none

interface owgm_out_if;
	logic                               valid;
	logic                               ready;
	logic [owgm_pkg::LEVEL_W-1:0]       read_level;
	logic [owgm_pkg::DROP_W-1:0]        dropped_count;

	modport source(output valid, read_level, dropped_count, input ready);
	modport sink(input valid, read_level, dropped_count, output ready);
endinterface

`default_nettype wire

@@ rtl/octant_window_max_grid_3d.sv @@
// Octant window maximum grid, top level. An accumulate word merges its level into the
// grid at eight corner targets, and the next word is taken once its result is loaded:
// eight read-modify-write merges share the single grid RAM, one target per cycle.
// A read word looks up one cell and returns its level (zero outside the window).
// After reset a clearing pass zeroes every cell of the grid; no word is taken
// meanwhile, configuration writes are. Depends on owgm_*.
`default_nettype none

module octant_window_max_grid_3d #(
	parameter int COORD_BITS = owgm_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	owgm_in_if.sink                            item,
	owgm_out_if.source                         result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [owgm_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [owgm_pkg::PDATA_W-1:0]  pwdata,
	output logic      [owgm_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready
);

	owgm_pkg::cfg_t cfg;
	owgm_pkg::cmd_t cmd;
	owgm_pkg::sts_t sts;

	owgm_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	owgm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(item.valid),
		.in_func(item.func),
		.in_ready(item.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.sts(sts),
		.cmd(cmd)
	);

	owgm_dp #(
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd(cmd),
		.sts(sts),
		.in_func(item.func),
		.in_x(item.cell_x),
		.in_y(item.cell_y),
		.in_z(item.cell_z),
		.in_level(item.cell_level),
		.read_level(result.read_level),
		.dropped_count(result.dropped_count)
	);

endmodule

`default_nettype wire

@@ rtl/owgm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on owgm_pkg for default sizes only.
`default_nettype none

module owgm_ram #(
	parameter int WIDTH = owgm_pkg::LEVEL_W,
	parameter int DEPTH = 2 ** (3 * owgm_pkg::COORD_BITS_DEF),
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/owgm_cfg.sv @@
// APB-style configuration registers: shifts per axis and half-resolution mode.
// Depends on owgm_pkg for the register map and cfg_t.
`default_nettype none

module owgm_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [owgm_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [owgm_pkg::PDATA_W-1:0]  pwdata,
	output logic      [owgm_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	output owgm_pkg::cfg_t                     cfg
);

	owgm_pkg::cfg_t   cfg_q;
	owgm_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx = paddr[3:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shift_x <= owgm_pkg::SHIFT_W'(1);
			cfg_q.shift_y <= owgm_pkg::SHIFT_W'(1);
			cfg_q.shift_z <= owgm_pkg::SHIFT_W'(1);
			cfg_q.half_res <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				owgm_pkg::REG_SHIFT_X: cfg_q.shift_x <= pwdata[owgm_pkg::SHIFT_W-1:0];
				owgm_pkg::REG_SHIFT_Y: cfg_q.shift_y <= pwdata[owgm_pkg::SHIFT_W-1:0];
				owgm_pkg::REG_SHIFT_Z: cfg_q.shift_z <= pwdata[owgm_pkg::SHIFT_W-1:0];
				owgm_pkg::REG_HALF_RES: cfg_q.half_res <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			owgm_pkg::REG_SHIFT_X: prdata = owgm_pkg::PDATA_W'(cfg_q.shift_x);
			owgm_pkg::REG_SHIFT_Y: prdata = owgm_pkg::PDATA_W'(cfg_q.shift_y);
			owgm_pkg::REG_SHIFT_Z: prdata = owgm_pkg::PDATA_W'(cfg_q.shift_z);
			owgm_pkg::REG_HALF_RES: prdata = owgm_pkg::PDATA_W'(cfg_q.half_res);
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/owgm_ctrl.sv @@
// Controller of the octant window maximum grid: clearing pass, corner sequencing
// and the handshakes of both channels. Depends on owgm_pkg.
`default_nettype none

module owgm_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_func,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire owgm_pkg::sts_t sts,
	output owgm_pkg::cmd_t      cmd
);

	owgm_pkg::ctrl_state_t state_q;
	owgm_pkg::ctrl_state_t state_nxt;
	logic                  out_valid_q;

	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			owgm_pkg::ST_CLEAR: begin
				if (sts.clr_last) begin
					state_nxt = owgm_pkg::ST_IDLE;
				end
			end
			owgm_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (in_func == owgm_pkg::FUNC_READ) ? owgm_pkg::ST_READ
						: owgm_pkg::ST_ACC;
				end
			end
			owgm_pkg::ST_ACC: begin
				if (sts.corner_last) begin
					state_nxt = owgm_pkg::ST_FLUSH;
				end
			end
			owgm_pkg::ST_FLUSH: state_nxt = owgm_pkg::ST_DONE;
			owgm_pkg::ST_READ: state_nxt = owgm_pkg::ST_DONE;
			owgm_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = owgm_pkg::ST_IDLE;
				end
			end
			default: state_nxt = owgm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			owgm_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
			owgm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			owgm_pkg::ST_ACC: cmd.issue = 1'b1;
			owgm_pkg::ST_READ: cmd.read_issue = 1'b1;
			owgm_pkg::ST_DONE: cmd.load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= owgm_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A new result may only land in an empty or draining output register.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken word");

	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == owgm_pkg::ST_FLUSH |=> state_q == owgm_pkg::ST_DONE)
		else $error("flush not followed by result stage");

	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !in_ready)
		else $error("item taken during clearing pass");

endmodule

`default_nettype wire

@@ rtl/owgm_dp.sv @@
// Datapath of the octant window maximum grid: target address unit, grid RAM with
// a one-stage read-modify-write merge, drop counter and result register.
// Depends on owgm_pkg and owgm_ram.
`default_nettype none

module owgm_dp #(
	parameter int COORD_BITS = owgm_pkg::COORD_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire owgm_pkg::cfg_t                      cfg,
	input  wire owgm_pkg::cmd_t                      cmd,
	output owgm_pkg::sts_t                           sts,
	input  wire logic                                in_func,
	input  wire logic signed [owgm_pkg::CELL_W-1:0]  in_x,
	input  wire logic signed [owgm_pkg::CELL_W-1:0]  in_y,
	input  wire logic signed [owgm_pkg::CELL_W-1:0]  in_z,
	input  wire logic        [owgm_pkg::LEVEL_W-1:0] in_level,
	output logic             [owgm_pkg::LEVEL_W-1:0] read_level,
	output logic             [owgm_pkg::DROP_W-1:0]  dropped_count
);

	localparam int AW = 3 * COORD_BITS;
	localparam int DEPTH = 2 ** AW;
	localparam int TW = owgm_pkg::CELL_W + 1;
	localparam int WW = (COORD_BITS + 1 > TW) ? COORD_BITS + 1 : TW;
	localparam logic signed [WW-1:0] WIN_LO = WW'(-(2 ** (COORD_BITS - 1)));
	localparam logic signed [WW-1:0] WIN_HI = WW'((2 ** (COORD_BITS - 1)) - 1);

	// Target coordinate along one axis; halving is an arithmetic shift (floor).
	function automatic logic signed [WW-1:0] axis_target(
		input logic signed [owgm_pkg::CELL_W-1:0] c,
		input logic [owgm_pkg::SHIFT_W-1:0]       sh,
		input logic                               sub,
		input logic                               half
	);
		logic signed [TW-1:0] t;
		logic signed [TW-1:0] h;
		t = TW'(c) - (sub ? TW'(sh) : TW'(0));
		h = half ? (t >>> 1) : t;
		return WW'(h);
	endfunction

	function automatic logic axis_in_win(input logic signed [WW-1:0] v);
		return (v >= WIN_LO) && (v <= WIN_HI);
	endfunction

	// Biasing by half the window flips the top bit of an in-window value.
	function automatic logic [COORD_BITS-1:0] axis_index(input logic signed [WW-1:0] v);
		return {~v[COORD_BITS-1], v[COORD_BITS-2:0]};
	endfunction

	logic                                func_q;
	logic signed [owgm_pkg::CELL_W-1:0]  x_q;
	logic signed [owgm_pkg::CELL_W-1:0]  y_q;
	logic signed [owgm_pkg::CELL_W-1:0]  z_q;
	logic        [owgm_pkg::LEVEL_W-1:0] level_q;
	logic        [owgm_pkg::CORNER_W-1:0] corner_q;
	logic        [owgm_pkg::DROP_W-1:0]  drop_q;
	logic        [AW-1:0]                clr_q;
	logic                                rd_ok_q;
	logic                                valid_s1;
	logic        [AW-1:0]                addr_s1;
	logic        [owgm_pkg::LEVEL_W-1:0] out_level_q;
	logic        [owgm_pkg::DROP_W-1:0]  out_drop_q;

	logic                                half;
	logic signed [WW-1:0]                tx;
	logic signed [WW-1:0]                ty;
	logic signed [WW-1:0]                tz;
	logic                                in_win;
	logic        [AW-1:0]                taddr;
	logic                                ram_we;
	logic        [AW-1:0]                ram_waddr;
	logic        [owgm_pkg::LEVEL_W-1:0] ram_wdata;
	logic                                ram_re;
	logic        [owgm_pkg::LEVEL_W-1:0] ram_rdata;
	logic        [owgm_pkg::LEVEL_W-1:0] merged;

	// A read item uses the raw cell: no corner offset and no halving.
	assign half = cfg.half_res && (func_q == owgm_pkg::FUNC_ACC);
	assign tx = axis_target(x_q, cfg.shift_x, corner_q[0] && (func_q == owgm_pkg::FUNC_ACC), half);
	assign ty = axis_target(y_q, cfg.shift_y, corner_q[1] && (func_q == owgm_pkg::FUNC_ACC), half);
	assign tz = axis_target(z_q, cfg.shift_z, corner_q[2] && (func_q == owgm_pkg::FUNC_ACC), half);
	assign in_win = axis_in_win(tx) && axis_in_win(ty) && axis_in_win(tz);
	assign taddr = {axis_index(tx), axis_index(ty), axis_index(tz)};

	assign merged = (ram_rdata > level_q) ? ram_rdata : level_q;
	assign ram_re = (cmd.issue || cmd.read_issue) && in_win;
	assign ram_we = cmd.clr_step || valid_s1;
	assign ram_waddr = cmd.clr_step ? clr_q : addr_s1;
	assign ram_wdata = cmd.clr_step ? '0 : merged;

	assign sts.clr_last = &clr_q;
	assign sts.corner_last = &corner_q;
	assign read_level = out_level_q;
	assign dropped_count = out_drop_q;

	owgm_ram #(
		.WIDTH(owgm_pkg::LEVEL_W),
		.DEPTH(DEPTH)
	) u_grid (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(taddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			corner_q <= '0;
			drop_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.capture) begin
				corner_q <= '0;
				drop_q <= '0;
			end else if (cmd.issue) begin
				corner_q <= corner_q + owgm_pkg::CORNER_W'(1);
				if (!in_win) begin
					drop_q <= drop_q + owgm_pkg::DROP_W'(1);
				end
			end
			valid_s1 <= cmd.issue && in_win;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= in_func;
			x_q <= in_x;
			y_q <= in_y;
			z_q <= in_z;
			level_q <= in_level;
		end
		if (cmd.read_issue) begin
			rd_ok_q <= in_win;
		end
		addr_s1 <= taddr;
		if (cmd.load_out) begin
			if (func_q == owgm_pkg::FUNC_READ) begin
				out_level_q <= rd_ok_q ? ram_rdata : '0;
				out_drop_q <= '0;
			end else begin
				out_level_q <= '0;
				out_drop_q <= drop_q;
			end
		end
	end

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_step && valid_s1))
		else $error("clearing pass and merge write collide");

	a_drop_range: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q <= owgm_pkg::DROP_W'(8))
		else $error("drop count beyond eight corners");

	a_merge_src: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(cmd.issue))
		else $error("merge write without an issued target");

endmodule

`default_nettype wire

@@ dv/octant_window_max_grid_3d_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for octant_window_max_grid_3d: accumulate and read words
// with random idling, checked against an in-bench model of the level grid.
// Depends on owgm_pkg, owgm_in_if, owgm_out_if and the block's RTL.

module octant_window_max_grid_3d_tb;

	localparam int COORD_BITS = owgm_pkg::COORD_BITS_DEF;
	localparam int CELL_W = owgm_pkg::CELL_W;
	localparam int LEVEL_W = owgm_pkg::LEVEL_W;
	localparam int DROP_W = owgm_pkg::DROP_W;
	localparam int SHIFT_W = owgm_pkg::SHIFT_W;
	localparam int PADDR_W = owgm_pkg::PADDR_W;
	localparam int PDATA_W = owgm_pkg::PDATA_W;
	localparam int AXIS_CELLS = 1 << COORD_BITS;
	localparam int AXIS_HALF = 1 << (COORD_BITS - 1);
	localparam int GRID_CELLS = 1 << (3 * COORD_BITS);
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [LEVEL_W-1:0] read_level;
		logic [DROP_W-1:0]  dropped_count;
	} grid_result_t;

	typedef struct {
		int x;
		int y;
		int z;
	} grid_point_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	owgm_in_if  word_in();
	owgm_out_if word_out();

	octant_window_max_grid_3d #(
		.COORD_BITS(COORD_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(word_in),
		.result(word_out),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Model state: the level grid and the window settings as last written.
	logic [LEVEL_W-1:0] level_grid [GRID_CELLS];
	owgm_pkg::cfg_t     window_cfg;
	grid_point_t        recent_points[$];
	grid_result_t       pending_results[$];
	int                 mismatch_count;
	bit                 idling_on;
	bit                 long_hold_pending;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic bit in_window(int v);
		return v >= -AXIS_HALF && v < AXIS_HALF;
	endfunction

	function automatic int grid_addr(int x, int y, int z);
		return (((x + AXIS_HALF) * AXIS_CELLS + (y + AXIS_HALF)) * AXIS_CELLS
			+ (z + AXIS_HALF)) % GRID_CELLS;
	endfunction

	// Applies one word to the model grid and returns the result it should give.
	function automatic grid_result_t merge_word(logic func, int bx, int by, int bz,
		logic [LEVEL_W-1:0] level);
		grid_result_t r;
		grid_point_t  p;
		int           sx, sy, sz, tx, ty, tz, a, c;
		r = '0;
		sx = int'(window_cfg.shift_x);
		sy = int'(window_cfg.shift_y);
		sz = int'(window_cfg.shift_z);
		if (func == owgm_pkg::FUNC_READ) begin
			if (in_window(bx) && in_window(by) && in_window(bz))
				r.read_level = level_grid[grid_addr(bx, by, bz)];
		end else begin
			for (c = 0; c < 8; c++) begin
				tx = bx - (((c & 1) != 0) ? sx : 0);
				ty = by - (((c & 2) != 0) ? sy : 0);
				tz = bz - (((c & 4) != 0) ? sz : 0);
				if (window_cfg.half_res) begin
					// Arithmetic shift of a signed int rounds toward minus infinity.
					tx = tx >>> 1;
					ty = ty >>> 1;
					tz = tz >>> 1;
				end
				if (in_window(tx) && in_window(ty) && in_window(tz)) begin
					a = grid_addr(tx, ty, tz);
					if (level > level_grid[a])
						level_grid[a] = level;
					p.x = tx;
					p.y = ty;
					p.z = tz;
					recent_points.push_back(p);
					if (recent_points.size() > 64)
						void'(recent_points.pop_front());
				end else begin
					r.dropped_count = r.dropped_count + 1'b1;
				end
			end
		end
		return r;
	endfunction

	// Idle length: usually none or short, now and then long.
	function automatic int pick_gap(bit allow_zero);
		int r;
		r = $urandom_range(0, 99);
		if (allow_zero && r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Register write followed by a read-back over the configuration port.
	task automatic write_reg(input owgm_pkg::reg_idx_t idx, input logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] readback;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== value) begin
			$error("register %0d: expected %0h, got %0h", idx, value, readback);
			mismatch_count++;
		end
	endtask

	task automatic program_window(input int sx, input int sy, input int sz, input int hr);
		write_reg(owgm_pkg::REG_SHIFT_X, PDATA_W'(sx));
		write_reg(owgm_pkg::REG_SHIFT_Y, PDATA_W'(sy));
		write_reg(owgm_pkg::REG_SHIFT_Z, PDATA_W'(sz));
		write_reg(owgm_pkg::REG_HALF_RES, PDATA_W'(hr));
		window_cfg.shift_x = SHIFT_W'(sx);
		window_cfg.shift_y = SHIFT_W'(sy);
		window_cfg.shift_z = SHIFT_W'(sz);
		window_cfg.half_res = hr[0];
	endtask

	// Offers one word and records its expected result once it is taken.
	task automatic send_word(input logic func, input int x, input int y, input int z,
		input int level);
		int                 gap;
		logic [CELL_W-1:0]  cx, cy, cz;
		logic [LEVEL_W-1:0] lv;
		cx = CELL_W'(x);
		cy = CELL_W'(y);
		cz = CELL_W'(z);
		lv = LEVEL_W'(level);
		gap = idling_on ? pick_gap(1'b1) : 0;
		@(negedge clk);
		if (gap > 0) begin
			word_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		word_in.valid <= 1'b1;
		word_in.func <= func;
		word_in.cell_x <= cx;
		word_in.cell_y <= cy;
		word_in.cell_z <= cz;
		word_in.cell_level <= lv;
		do @(posedge clk); while (!word_in.ready);
		pending_results.push_back(merge_word(func, int'($signed(cx)), int'($signed(cy)),
			int'($signed(cz)), lv));
	endtask

	task automatic send_random_word();
		logic        func;
		int          x, y, z, level;
		grid_point_t p;
		int          r;
		func = ($urandom_range(0, 9) < 6) ? owgm_pkg::FUNC_ACC : owgm_pkg::FUNC_READ;
		if (func == owgm_pkg::FUNC_READ && recent_points.size() > 0
			&& $urandom_range(0, 9) < 7) begin
			p = recent_points[$urandom_range(0, recent_points.size() - 1)];
			x = p.x;
			y = p.y;
			z = p.z;
		end else if ($urandom_range(0, 1) == 0) begin
			// A small cluster keeps targets overlapping so the maximum matters.
			x = int'($urandom_range(0, 8)) - 4;
			y = int'($urandom_range(0, 8)) - 4;
			z = int'($urandom_range(0, 8)) - 4;
		end else begin
			x = int'($urandom_range(0, 63)) - 32;
			y = int'($urandom_range(0, 63)) - 32;
			z = int'($urandom_range(0, 63)) - 32;
		end
		r = $urandom_range(0, 19);
		level = (r == 0) ? 0 : (r == 1) ? 255 : int'($urandom_range(0, 255));
		send_word(func, x, y, z, level);
	endtask

	task automatic drain_results();
		@(negedge clk);
		word_in.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Reset settings: grid cleared, unit shifts, full resolution.
	task automatic test_reset_state();
		send_word(owgm_pkg::FUNC_READ, 0, 0, 0, 9);
		send_word(owgm_pkg::FUNC_ACC, 0, 0, 0, 100);
		send_word(owgm_pkg::FUNC_READ, -1, -1, -1, 0);
		send_word(owgm_pkg::FUNC_ACC, -32, -32, -32, 255);
		send_word(owgm_pkg::FUNC_READ, -32, -32, -32, 0);
		send_word(owgm_pkg::FUNC_ACC, 0, 0, 0, 50);
		send_word(owgm_pkg::FUNC_READ, 0, 0, 0, 0);
		send_word(owgm_pkg::FUNC_ACC, 31, 31, 31, 0);
		send_word(owgm_pkg::FUNC_READ, 31, 31, 31, 0);
		drain_results();
	endtask

	// Zero shifts: all eight corners land on one cell.
	task automatic test_zero_shift();
		program_window(0, 0, 0, 0);
		send_word(owgm_pkg::FUNC_ACC, 5, -5, 7, 77);
		send_word(owgm_pkg::FUNC_READ, 5, -5, 7, 0);
		send_word(owgm_pkg::FUNC_ACC, -32, 31, -32, 255);
		send_word(owgm_pkg::FUNC_READ, -32, 31, -32, 0);
		drain_results();
	endtask

	// Largest shifts, with and without halving.
	task automatic test_max_shift();
		program_window(31, 31, 31, 0);
		send_word(owgm_pkg::FUNC_ACC, 0, 0, 0, 33);
		send_word(owgm_pkg::FUNC_ACC, 31, 31, 31, 200);
		send_word(owgm_pkg::FUNC_READ, 0, 0, 0, 0);
		send_word(owgm_pkg::FUNC_READ, 31, 0, 31, 0);
		drain_results();
		program_window(31, 31, 31, 1);
		send_word(owgm_pkg::FUNC_ACC, -32, -32, -32, 201);
		send_word(owgm_pkg::FUNC_ACC, 31, -32, 0, 1);
		send_word(owgm_pkg::FUNC_READ, -32, -32, -32, 0);
		send_word(owgm_pkg::FUNC_READ, 0, -32, -16, 0);
		send_word(owgm_pkg::FUNC_READ, 15, -16, 0, 0);
		drain_results();
	endtask

	task automatic test_random_phases();
		int phase, n;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: program_window(31, 31, 31, 0);
				1: program_window(0, 0, 0, 1);
				default: program_window($urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 31), $urandom_range(0, 1));
			endcase
			// One phase runs flat out on both sides.
			idling_on = (phase != 3);
			for (n = 0; n < 60; n++)
				send_random_word();
			drain_results();
		end
		idling_on = 1'b1;
	endtask

	// The sink holds off for a long stretch while words keep coming.
	task automatic test_backpressure();
		int n;
		program_window(1, 2, 3, 0);
		idling_on = 1'b0;
		long_hold_pending = 1'b1;
		for (n = 0; n < 24; n++)
			send_random_word();
		drain_results();
		idling_on = 1'b1;
	endtask

	always @(posedge clk) begin : check_results
		grid_result_t want;
		if (word_out.valid && word_out.ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with no expectation waiting");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (word_out.read_level !== want.read_level) begin
					$error("read_level: expected %0d, got %0d", want.read_level,
						word_out.read_level);
					mismatch_count++;
				end
				if (word_out.dropped_count !== want.dropped_count) begin
					$error("dropped_count: expected %0d, got %0d", want.dropped_count,
						word_out.dropped_count);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : result_sink
		word_out.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_pending) begin
				long_hold_pending = 1'b0;
				word_out.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
			end else if (idling_on && $urandom_range(0, 3) == 0) begin
				word_out.ready <= 1'b0;
				repeat (pick_gap(1'b0) - 1) @(negedge clk);
			end else begin
				word_out.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#15_000_000;
		$display("octant_window_max_grid_3d_tb: FAIL");
		$finish;
	end

	initial begin : run_tests
		foreach (level_grid[i])
			level_grid[i] = '0;
		window_cfg.shift_x = SHIFT_W'(1);
		window_cfg.shift_y = SHIFT_W'(1);
		window_cfg.shift_z = SHIFT_W'(1);
		window_cfg.half_res = 1'b0;
		mismatch_count = 0;
		idling_on = 1'b1;
		long_hold_pending = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		word_in.valid <= 1'b0;
		word_in.func <= owgm_pkg::FUNC_ACC;
		word_in.cell_x <= '0;
		word_in.cell_y <= '0;
		word_in.cell_z <= '0;
		word_in.cell_level <= '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_zero_shift();
		test_max_shift();
		test_random_phases();
		test_backpressure();

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("octant_window_max_grid_3d_tb: PASS");
		end else begin
			$display("octant_window_max_grid_3d_tb: FAIL");
		end
		$finish;
	end

endmodule
